// ===== rtl/cnrl_pkg.sv =====
// cnrl_pkg: shared constants, codes and controller/datapath structs for the
// compressed n-gram row lookup. No dependencies.
`default_nettype none
package cnrl_pkg;

    localparam int TABLES      = 3;
    localparam int MAX_WORDS   = 1024;
    localparam int MAX_BLOCKS  = 256;
    localparam int BLOCK_BYTES = 64;
    localparam int ROW_BITS    = 20;
    localparam int CTX_BITS    = 20;

    localparam int WORD_DEPTH  = TABLES * MAX_WORDS;
    localparam int HDR_DEPTH   = TABLES * MAX_BLOCKS;
    localparam int DATA_DEPTH  = TABLES * MAX_BLOCKS * BLOCK_BYTES;
    localparam int WORD_AW     = $clog2(WORD_DEPTH);
    localparam int HDR_AW      = $clog2(HDR_DEPTH);
    localparam int DATA_AW     = $clog2(DATA_DEPTH);
    localparam int STREAM_BITS = BLOCK_BYTES * 8;
    localparam int POS_W       = $clog2(STREAM_BITS) + 1;
    localparam int MAX_CODE    = 32;

    typedef enum logic [1:0] {
        ACT_LOAD_WORD = 2'd0,
        ACT_LOAD_HDR  = 2'd1,
        ACT_LOAD_BYTE = 2'd2,
        ACT_QUERY     = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        CFG_BASE_BITS = 3'd0,
        CFG_WORDS_0   = 3'd1,
        CFG_WORDS_1   = 3'd2,
        CFG_WORDS_2   = 3'd3,
        CFG_BLOCKS_0  = 3'd4,
        CFG_BLOCKS_1  = 3'd5,
        CFG_BLOCKS_2  = 3'd6,
        CFG_UNUSED    = 3'd7
    } t_cfg_idx;

    // controller to datapath
    typedef struct packed {
        logic q_start;
        logic wchk;
        logic hdr_rd_c;
        logic scmp;
        logic hdr_rd_a;
        logic blkb;
        logic blkc;
        logic row_start;
        logic fetch;
        logic bit_step;
        logic code_done;
        logic eval_next;
        logic fin_hit;
        logic fin_miss;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic q_miss;
        logic srch_more;
        logic a_over;
        logic row_more;
        logic pos_over;
        logic byte_ok;
        logic code_done;
        logic bit_miss;
        logic code_sel;
        logic hit;
        logic stop;
    } t_sts;

endpackage
`default_nettype wire

// ===== rtl/cnrl_ram.sv =====
// cnrl_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.
`default_nettype none
module cnrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire                     i_re,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/cnrl_ctrl.sv =====
// cnrl_ctrl: query sequencer for the n-gram row lookup.
// Depends on cnrl_pkg; drives the datapath through t_cmd, reads t_sts.
`default_nettype none
module cnrl_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_accept,
    input  wire [1:0]      i_action,
    input  cnrl_pkg::t_sts i_sts,
    output cnrl_pkg::t_cmd o_cmd,
    output logic           o_busy
);
    import cnrl_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_WCHK = 10'b0000000010,
        S_SLOOP = 10'b0000000100,
        S_SCMP = 10'b0000001000,
        S_BLKA = 10'b0000010000,
        S_BLKB = 10'b0000100000,
        S_BLKC = 10'b0001000000,
        S_ROW  = 10'b0010000000,
        S_BITS = 10'b0100000000,
        S_EVAL = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    t_cmd   cmd;

    // next state and commands
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_accept && t_action'(i_action) == ACT_QUERY) begin
                    cmd.q_start = 1'b1;
                    n_state     = S_WCHK;
                end
            end
            S_WCHK: begin
                if (i_sts.q_miss) begin
                    cmd.fin_miss = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    cmd.wchk = 1'b1;
                    n_state  = S_SLOOP;
                end
            end
            S_SLOOP: begin
                if (i_sts.srch_more) begin
                    cmd.hdr_rd_c = 1'b1;
                    n_state      = S_SCMP;
                end else begin
                    n_state = S_BLKA;
                end
            end
            S_SCMP: begin
                cmd.scmp = 1'b1;
                n_state  = S_SLOOP;
            end
            S_BLKA: begin
                if (i_sts.a_over) begin
                    cmd.fin_miss = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    cmd.hdr_rd_a = 1'b1;
                    n_state      = S_BLKB;
                end
            end
            S_BLKB: begin
                cmd.blkb = 1'b1;
                n_state  = S_BLKC;
            end
            S_BLKC: begin
                cmd.blkc = 1'b1;
                n_state  = S_ROW;
            end
            S_ROW: begin
                if (i_sts.row_more) begin
                    cmd.row_start = 1'b1;
                    n_state       = S_BITS;
                end else begin
                    cmd.fin_miss = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_BITS: begin
                priority if (i_sts.code_done) begin
                    cmd.code_done = 1'b1;
                    if (i_sts.code_sel) begin
                        n_state = S_EVAL;
                    end
                end else if (i_sts.pos_over) begin
                    cmd.fin_miss = 1'b1;
                    n_state      = S_IDLE;
                end else if (!i_sts.byte_ok) begin
                    cmd.fetch = 1'b1;
                end else if (i_sts.bit_miss) begin
                    cmd.fin_miss = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    cmd.bit_step = 1'b1;
                end
            end
            S_EVAL: begin
                priority if (i_sts.hit) begin
                    cmd.fin_hit = 1'b1;
                    n_state     = S_IDLE;
                end else if (i_sts.stop) begin
                    cmd.fin_miss = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    cmd.eval_next = 1'b1;
                    n_state       = S_ROW;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != S_IDLE);
endmodule
`default_nettype wire

// ===== rtl/cnrl_dp.sv =====
// cnrl_dp: stores, config registers, search and bit-stream decode datapath.
// Depends on cnrl_pkg and cnrl_ram; commanded by cnrl_ctrl.
`default_nettype none
module cnrl_dp (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_accept,
    input  wire                             i_cfg_we,
    input  wire [2:0]                       i_cfg_index,
    input  wire [10:0]                      i_cfg_data,
    input  wire [1:0]                       i_action,
    input  wire [1:0]                       i_table_index,
    input  wire [9:0]                       i_word_id,
    input  wire [7:0]                       i_block_index,
    input  wire [5:0]                       i_byte_index,
    input  wire signed [20:0]               i_range_start,
    input  wire [19:0]                      i_range_end,
    input  wire [cnrl_pkg::ROW_BITS-1:0]    i_row_value,
    input  wire [19:0]                      i_context_value,
    input  wire [7:0]                       i_data_byte,
    input  cnrl_pkg::t_cmd                  i_cmd,
    output cnrl_pkg::t_sts                  o_sts,
    output logic                            o_valid,
    output logic                            o_found,
    output logic [31:0]                     o_count_value,
    output logic [cnrl_pkg::ROW_BITS-1:0]   o_row_offset_out
);
    import cnrl_pkg::*;

    // configuration
    logic [4:0]  r_base;
    logic [10:0] r_words  [TABLES];
    logic [7:0]  r_blocks [TABLES];

    // query state
    logic [1:0]          r_t;
    logic [9:0]          r_wid;
    logic [19:0]         r_target;
    logic signed [20:0]  r_begin;
    logic [19:0]         r_end;
    logic [7:0]          r_a, r_b;
    logic [ROW_BITS:0]   r_offset;
    logic [ROW_BITS-1:0] r_blk_off, r_end_off;
    logic [33:0]         r_ctx;
    logic [POS_W-1:0]    r_pos;
    logic                r_byte_ok;
    logic                r_in_value;
    logic                r_sel;
    logic [5:0]          r_width, r_left;
    logic [31:0]         r_val, r_cv, r_cnt;

    // outputs
    logic                r_valid, r_found;
    logic [31:0]         r_count;
    logic [ROW_BITS-1:0] r_row;

    // memory ports
    logic                 word_we, hdr_we, data_we, word_re, hdr_re;
    logic [WORD_AW-1:0]   word_waddr, word_raddr;
    logic [HDR_AW-1:0]    hdr_waddr, hdr_raddr;
    logic [DATA_AW-1:0]   data_waddr, data_raddr;
    logic [40:0]          word_rdata;
    logic [ROW_BITS+CTX_BITS-1:0] hdr_rdata;
    logic [7:0]           data_rdata;

    logic                 t_ok, in_t_ok;
    logic [10:0]          words_sel;
    logic [7:0]           blocks_sel, hdr_idx;
    logic [8:0]           ab_sum;
    logic [7:0]           mid;
    logic [ROW_BITS-1:0]  hdr_row;
    logic [19:0]          hdr_ctx;
    logic signed [21:0]   begin_s, off_s, row_s;
    logic signed [20:0]   rd_begin;
    logic [19:0]          rd_end;
    logic                 cur_bit;
    logic [6:0]           width_step;
    logic [33:0]          cur;
    logic                 ge_begin, le_end;

    function automatic logic rd_end_lt_row(input logic [19:0] e,
                                           input logic [ROW_BITS-1:0] r);
        rd_end_lt_row = ({12'd0, e} < 32'(r));
    endfunction

    assign in_t_ok = ({30'd0, i_table_index} < TABLES);
    assign t_ok    = ({30'd0, r_t} < TABLES);

    // select per-table config
    always_comb begin
        words_sel  = '0;
        blocks_sel = '0;
        for (int k = 0; k < TABLES; k++) begin
            if (r_t == 2'(k)) begin
                words_sel  = r_words[k];
                blocks_sel = r_blocks[k];
            end
        end
    end

    // loads go straight to the stores
    assign word_we    = i_accept && t_action'(i_action) == ACT_LOAD_WORD && in_t_ok;
    assign hdr_we     = i_accept && t_action'(i_action) == ACT_LOAD_HDR && in_t_ok;
    assign data_we    = i_accept && t_action'(i_action) == ACT_LOAD_BYTE && in_t_ok;
    assign word_waddr = WORD_AW'({i_table_index, i_word_id});
    assign hdr_waddr  = HDR_AW'({i_table_index, i_block_index});
    assign data_waddr = DATA_AW'({i_table_index, i_block_index, i_byte_index});

    assign word_re    = i_cmd.q_start && in_t_ok;
    assign word_raddr = word_waddr;

    // header read address
    assign ab_sum = {1'b0, r_a} + {1'b0, r_b};
    assign mid    = ab_sum[8:1];
    always_comb begin
        priority if (i_cmd.hdr_rd_c) begin
            hdr_idx = mid;
        end else if (i_cmd.hdr_rd_a) begin
            hdr_idx = r_a;
        end else begin
            hdr_idx = r_a + 8'd1;
        end
    end
    assign hdr_re    = i_cmd.hdr_rd_c || i_cmd.hdr_rd_a || i_cmd.blkb;
    assign hdr_raddr = HDR_AW'({r_t, hdr_idx});
    assign hdr_row   = hdr_rdata[ROW_BITS+CTX_BITS-1:CTX_BITS];
    assign hdr_ctx   = hdr_rdata[CTX_BITS-1:0];

    assign data_raddr = DATA_AW'({r_t, r_a, r_pos[POS_W-2:3]});

    cnrl_ram #(.WIDTH(41), .DEPTH(WORD_DEPTH)) u_word_ram (
        .i_clk(i_clk), .i_we(word_we), .i_waddr(word_waddr),
        .i_wdata({i_range_start, i_range_end}),
        .i_re(word_re), .i_raddr(word_raddr), .o_rdata(word_rdata)
    );
    cnrl_ram #(.WIDTH(ROW_BITS+CTX_BITS), .DEPTH(HDR_DEPTH)) u_hdr_ram (
        .i_clk(i_clk), .i_we(hdr_we), .i_waddr(hdr_waddr),
        .i_wdata({i_row_value, i_context_value}),
        .i_re(hdr_re), .i_raddr(hdr_raddr), .o_rdata(hdr_rdata)
    );
    cnrl_ram #(.WIDTH(8), .DEPTH(DATA_DEPTH)) u_data_ram (
        .i_clk(i_clk), .i_we(data_we), .i_waddr(data_waddr), .i_wdata(i_data_byte),
        .i_re(i_cmd.fetch), .i_raddr(data_raddr), .o_rdata(data_rdata)
    );

    assign rd_begin = word_rdata[40:20];
    assign rd_end   = word_rdata[19:0];

    // comparisons
    assign begin_s  = {r_begin[20], r_begin};
    assign off_s    = $signed({1'b0, r_offset});
    assign row_s    = $signed({2'b00, hdr_row});
    assign ge_begin = (off_s >= begin_s);
    assign le_end   = (r_offset <= {1'b0, r_end});

    // current context of the decoded row
    always_comb begin
        priority if (r_offset == {1'b0, r_blk_off}) begin
            cur = r_ctx;
        end else if (off_s > begin_s) begin
            cur = {2'b00, r_cv} + r_ctx;
        end else begin
            cur = {2'b00, r_cv};
        end
    end

    assign cur_bit    = data_rdata[3'd7 - r_pos[2:0]];
    assign width_step = {1'b0, r_width} + {2'b00, r_base};

    // status
    always_comb begin
        o_sts.q_miss    = !t_ok || ({1'b0, r_wid} >= words_sel) || (rd_begin == -21'sd1)
                          || (blocks_sel == 8'd0);
        o_sts.srch_more = ({1'b0, r_b} > ({1'b0, r_a} + 9'd1));
        o_sts.a_over    = (({1'b0, r_a} + 9'd1) >= 9'(MAX_BLOCKS));
        o_sts.row_more  = (r_offset < {1'b0, r_end_off});
        o_sts.pos_over  = r_pos[POS_W-1];
        o_sts.byte_ok   = r_byte_ok;
        o_sts.code_done = r_in_value && (r_left == 6'd0);
        o_sts.bit_miss  = !r_in_value && !cur_bit && (width_step > 7'(MAX_CODE));
        o_sts.code_sel  = r_sel;
        o_sts.hit       = ge_begin && le_end && (cur == {14'd0, r_target});
        o_sts.stop      = !le_end || ((cur > {14'd0, r_target}) && ge_begin);
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= 5'd1;
            for (int k = 0; k < TABLES; k++) begin
                r_words[k]  <= '0;
                r_blocks[k] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_BASE_BITS: r_base <= i_cfg_data[4:0];
                CFG_WORDS_0:   r_words[0] <= i_cfg_data;
                CFG_WORDS_1:   if (TABLES > 1) r_words[1 % TABLES] <= i_cfg_data;
                CFG_WORDS_2:   if (TABLES > 2) r_words[2 % TABLES] <= i_cfg_data;
                CFG_BLOCKS_0:  r_blocks[0] <= i_cfg_data[7:0];
                CFG_BLOCKS_1:  if (TABLES > 1) r_blocks[1 % TABLES] <= i_cfg_data[7:0];
                CFG_BLOCKS_2:  if (TABLES > 2) r_blocks[2 % TABLES] <= i_cfg_data[7:0];
                CFG_UNUSED:    r_base <= r_base;
                default:       r_base <= r_base;
            endcase
        end
    end

    // query datapath
    always_ff @(posedge i_clk) begin
        if (i_cmd.q_start) begin
            r_t        <= i_table_index;
            r_wid      <= i_word_id;
            r_target   <= i_context_value;
            r_pos      <= '0;
            r_byte_ok  <= 1'b0;
        end
        if (i_cmd.wchk) begin
            r_begin <= rd_begin;
            r_end   <= rd_end;
            r_a     <= '0;
            r_b     <= blocks_sel - 8'd1;
        end
        // narrow the header search
        if (i_cmd.scmp) begin
            priority if (rd_end_lt_row(r_end, hdr_row)) begin
                r_b <= mid;
            end else if (begin_s >= row_s) begin
                r_a <= mid;
            end else if (hdr_ctx > r_target) begin
                r_b <= mid;
            end else begin
                r_a <= mid;
            end
        end
        if (i_cmd.blkb) begin
            r_offset  <= {1'b0, hdr_row};
            r_blk_off <= hdr_row;
            r_ctx     <= {14'd0, hdr_ctx};
        end
        if (i_cmd.blkc) begin
            r_end_off <= hdr_row;
        end
        // start a code
        if (i_cmd.row_start || (i_cmd.code_done && !r_sel)) begin
            r_width    <= {1'b0, r_base};
            r_in_value <= 1'b0;
            r_val      <= '0;
        end
        if (i_cmd.row_start) begin
            r_sel <= 1'b0;
        end
        if (i_cmd.code_done) begin
            if (r_sel) begin
                r_cnt <= r_val;
            end else begin
                r_cv  <= r_val;
                r_sel <= 1'b1;
            end
        end
        if (i_cmd.fetch) begin
            r_byte_ok <= 1'b1;
        end
        // consume one stream bit
        if (i_cmd.bit_step) begin
            if (!r_in_value) begin
                if (cur_bit) begin
                    r_in_value <= 1'b1;
                    r_left     <= r_width;
                end else begin
                    r_width <= width_step[5:0];
                end
            end else begin
                r_val  <= {r_val[30:0], cur_bit};
                r_left <= r_left - 6'd1;
            end
            r_pos <= r_pos + POS_W'(1);
            if (r_pos[2:0] == 3'd7) begin
                r_byte_ok <= 1'b0;
            end
        end
        if (i_cmd.eval_next) begin
            r_offset <= r_offset + (ROW_BITS+1)'(1);
            r_ctx    <= cur;
        end
    end

    // result registers; valid is a one-cycle strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.fin_hit || i_cmd.fin_miss;
        end
        if (i_cmd.fin_hit) begin
            r_found <= 1'b1;
            r_count <= r_cnt;
            r_row   <= r_offset[ROW_BITS-1:0];
        end else if (i_cmd.fin_miss) begin
            r_found <= 1'b0;
            r_count <= '0;
            r_row   <= '0;
        end
    end

    assign o_valid          = r_valid;
    assign o_found          = r_found;
    assign o_count_value    = r_count;
    assign o_row_offset_out = r_row;
endmodule
`default_nettype wire

// ===== rtl/compressed_ngram_row_lookup.sv =====
// Compressed n-gram row lookup. Loads give no result. A query runs a header search
// (at most 8 steps) to reach its block, then decodes its rows, fetching stream bytes
// as needed and reading the stream one bit at a time, until it finds a hit or a miss;
// the result strobes on o_valid the next cycle and cannot be stalled.
// Reset clears control and configuration; stores are not.
`default_nettype none
module compressed_ngram_row_lookup (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_we,
    input  wire [2:0]                     i_cfg_index,
    input  wire [10:0]                    i_cfg_data,
    input  wire                           i_start,
    output logic                          o_busy,
    input  wire [1:0]                     i_action,
    input  wire [1:0]                     i_table_index,
    input  wire [9:0]                     i_word_id,
    input  wire [7:0]                     i_block_index,
    input  wire [5:0]                     i_byte_index,
    input  wire signed [20:0]             i_range_start,
    input  wire [19:0]                    i_range_end,
    input  wire [cnrl_pkg::ROW_BITS-1:0]  i_row_value,
    input  wire [19:0]                    i_context_value,
    input  wire [7:0]                     i_data_byte,
    output logic                          o_valid,
    output logic                          o_found,
    output logic [31:0]                   o_count_value,
    output logic [cnrl_pkg::ROW_BITS-1:0] o_row_offset_out
);
    import cnrl_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic busy;
    logic accept;

    // take a transaction when idle
    assign accept = i_start && !busy;
    assign o_busy = busy;

    cnrl_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_accept(accept), .i_action(i_action),
        .i_sts(sts), .o_cmd(cmd), .o_busy(busy)
    );

    cnrl_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_accept(accept),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_action(i_action), .i_table_index(i_table_index), .i_word_id(i_word_id),
        .i_block_index(i_block_index), .i_byte_index(i_byte_index),
        .i_range_start(i_range_start), .i_range_end(i_range_end),
        .i_row_value(i_row_value), .i_context_value(i_context_value),
        .i_data_byte(i_data_byte), .i_cmd(cmd), .o_sts(sts),
        .o_valid(o_valid), .o_found(o_found), .o_count_value(o_count_value),
        .o_row_offset_out(o_row_offset_out)
    );
endmodule
`default_nettype wire
